### sv/v3n_pkg.sv
// Package for the 3-vector normalizer.
// Holds fixed widths and constants shared by the top level and the stage module.
`default_nettype none
package v3n_pkg;
   localparam int UNIT_BITS = 16;
   localparam int Q_BITS    = 17;
   localparam int FRAC_BITS = 15;
   localparam logic [UNIT_BITS-1:0] UNIT_MAX = 16'h7FFF;
endpackage
`default_nettype wire

### sv/vector3_normalize.sv
// Top level of the 3-vector normalizer: front stages, iteration stages, output register.
// Depends on v3n_pkg and v3n_stage.
//
//   channel  prefix  direction  beat
//   input    req_    in         comp_x, comp_y, comp_z
//   result   rsp_    out        unit_x, unit_y, unit_z, magnitude, zero_vector
//
// One beat may enter every cycle while req_stall is low.
// The depth is set by the bit-per-stage square root and unit quotient stages.
// A stall on rsp_ while rsp_valid is high freezes the whole pipeline and is passed back as req_stall.
// Synchronous reset clears the valid bits only.
`default_nettype none
module vector3_normalize #(
   parameter int COMPONENT_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [COMPONENT_BITS-1:0]   req_comp_x,
   input  wire logic signed [COMPONENT_BITS-1:0]   req_comp_y,
   input  wire logic signed [COMPONENT_BITS-1:0]   req_comp_z,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [v3n_pkg::UNIT_BITS-1:0]    rsp_unit_x,
   output logic signed [v3n_pkg::UNIT_BITS-1:0]    rsp_unit_y,
   output logic signed [v3n_pkg::UNIT_BITS-1:0]    rsp_unit_z,
   output logic [COMPONENT_BITS-1:0]               rsp_magnitude,
   output logic                                    rsp_zero_vector
);
   import v3n_pkg::*;

   localparam int CB = COMPONENT_BITS;
   localparam int SW = 2 * CB;
   localparam int DW = 2 * CB + 35;
   localparam int NS = (CB > Q_BITS) ? CB : Q_BITS;

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage A: absolute values
   logic                  a_valid_ff;
   logic [2:0][CB-1:0]    a_abs_ff, a_abs_in;
   logic [2:0]            a_neg_ff, a_neg_in;
   logic [2:0][CB-1:0]    raw;

   always_comb begin
      raw[0] = req_comp_x;
      raw[1] = req_comp_y;
      raw[2] = req_comp_z;
      for (int i = 0; i < 3; i++) begin
         a_neg_in[i] = raw[i][CB-1];
         a_abs_in[i] = a_neg_in[i] ? (~raw[i] + CB'(1)) : raw[i];
      end
   end

   // stage B: squares
   logic                  b_valid_ff;
   logic [2:0][SW-1:0]    b_sq_ff;
   logic [2:0]            b_neg_ff;

   // stage C: sum and initial remainders
   logic                  c_valid_ff;
   logic [SW-1:0]         c_s_ff;
   logic                  c_zero_ff;
   logic [2:0]            c_neg_ff;
   logic [2:0][DW-1:0]    c_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_abs_ff <= a_abs_in;
         a_neg_ff <= a_neg_in;
         for (int i = 0; i < 3; i++) begin
            b_sq_ff[i] <= SW'(a_abs_ff[i]) * SW'(a_abs_ff[i]);
            c_r_ff[i]  <= DW'(b_sq_ff[i]) << (2 * FRAC_BITS);
         end
         b_neg_ff  <= a_neg_ff;
         c_s_ff    <= b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
         c_zero_ff <= (b_sq_ff[0] == '0) && (b_sq_ff[1] == '0) && (b_sq_ff[2] == '0);
         c_neg_ff  <= b_neg_ff;
      end
   end

   // iteration stages
   logic [NS:0]                     p_valid;
   logic [NS:0][SW-1:0]             p_s;
   logic [NS:0]                     p_zero;
   logic [NS:0][2:0]                p_neg;
   logic [NS:0][SW-1:0]             p_rem;
   logic [NS:0][SW-1:0]             p_res;
   logic [NS:0][2:0][DW-1:0]        p_r;
   logic [NS:0][2:0][DW-1:0]        p_qs;
   logic [NS:0][2:0][Q_BITS-1:0]    p_q;

   assign p_valid[0] = c_valid_ff;
   assign p_s[0]     = c_s_ff;
   assign p_zero[0]  = c_zero_ff;
   assign p_neg[0]   = c_neg_ff;
   assign p_rem[0]   = c_s_ff;
   assign p_res[0]   = '0;
   assign p_r[0]     = c_r_ff;
   assign p_qs[0]    = '0;
   assign p_q[0]     = '0;

   generate
      for (genvar k = 0; k < NS; k++) begin : g_stage
         v3n_stage #(.CB(CB), .K(k)) u_stage (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (p_valid[k]),
            .in_s      (p_s[k]),
            .in_zero   (p_zero[k]),
            .in_neg    (p_neg[k]),
            .in_rem    (p_rem[k]),
            .in_res    (p_res[k]),
            .in_r      (p_r[k]),
            .in_qs     (p_qs[k]),
            .in_q      (p_q[k]),
            .out_valid (p_valid[k+1]),
            .out_s     (p_s[k+1]),
            .out_zero  (p_zero[k+1]),
            .out_neg   (p_neg[k+1]),
            .out_rem   (p_rem[k+1]),
            .out_res   (p_res[k+1]),
            .out_r     (p_r[k+1]),
            .out_qs    (p_qs[k+1]),
            .out_q     (p_q[k+1])
         );
      end
   endgenerate

   // output register
   logic                           o_valid_ff;
   logic [2:0][UNIT_BITS-1:0]      o_unit_ff, o_unit_in;
   logic [CB-1:0]                  o_mag_ff;
   logic                           o_zero_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (p_zero[NS]) begin
            o_unit_in[i] = '0;
         end else if (p_neg[NS][i]) begin
            o_unit_in[i] = UNIT_BITS'(~p_q[NS][i] + Q_BITS'(1));
         end else if (p_q[NS][i] > Q_BITS'(UNIT_MAX)) begin
            o_unit_in[i] = UNIT_MAX;
         end else begin
            o_unit_in[i] = p_q[NS][i][UNIT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= p_valid[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_unit_ff <= o_unit_in;
         o_mag_ff  <= p_res[NS][CB-1:0];
         o_zero_ff <= p_zero[NS];
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_unit_x      = o_unit_ff[0];
   assign rsp_unit_y      = o_unit_ff[1];
   assign rsp_unit_z      = o_unit_ff[2];
   assign rsp_magnitude   = o_mag_ff;
   assign rsp_zero_vector = o_zero_ff;

   a_zero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |-> rsp_magnitude == '0)
      else $error("zero vector with nonzero magnitude");

   a_nonzero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_vector |-> rsp_magnitude != '0)
      else $error("nonzero vector with zero magnitude");

   a_nonzero_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_vector |->
         (rsp_unit_x != '0) || (rsp_unit_y != '0) || (rsp_unit_z != '0))
      else $error("nonzero vector with all unit components zero");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
endmodule
`default_nettype wire

### sv/v3n_stage.sv
// One pipelined iteration: one root bit of the sum of squares when K < CB and one
// quotient bit of each unit component when K < Q_BITS. Depends on v3n_pkg.
`default_nettype none
module v3n_stage #(
   parameter int CB = 16,
   parameter int K  = 0
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                in_valid,
   input  wire logic [2*CB-1:0]                     in_s,
   input  wire logic                                in_zero,
   input  wire logic [2:0]                          in_neg,
   input  wire logic [2*CB-1:0]                     in_rem,
   input  wire logic [2*CB-1:0]                     in_res,
   input  wire logic [2:0][2*CB+34:0]               in_r,
   input  wire logic [2:0][2*CB+34:0]               in_qs,
   input  wire logic [2:0][v3n_pkg::Q_BITS-1:0]     in_q,
   output logic                                     out_valid,
   output logic [2*CB-1:0]                          out_s,
   output logic                                     out_zero,
   output logic [2:0]                               out_neg,
   output logic [2*CB-1:0]                          out_rem,
   output logic [2*CB-1:0]                          out_res,
   output logic [2:0][2*CB+34:0]                    out_r,
   output logic [2:0][2*CB+34:0]                    out_qs,
   output logic [2:0][v3n_pkg::Q_BITS-1:0]          out_q
);
   import v3n_pkg::*;

   localparam int SW = 2 * CB;
   localparam int DW = 2 * CB + 35;

   logic                      valid_ff;
   logic [SW-1:0]             s_ff;
   logic                      zero_ff;
   logic [2:0]                neg_ff;
   logic [SW-1:0]             rem_ff, rem_in;
   logic [SW-1:0]             res_ff, res_in;
   logic [2:0][DW-1:0]        r_ff, r_in;
   logic [2:0][DW-1:0]        qs_ff, qs_in;
   logic [2:0][Q_BITS-1:0]    q_ff, q_in;

   generate
      if (K < CB) begin : g_root
         localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * K);
         logic [SW-1:0] trial;
         always_comb begin
            trial = in_res + BIT;
            if (in_rem >= trial) begin
               rem_in = in_rem - trial;
               res_in = (in_res >> 1) + BIT;
            end else begin
               rem_in = in_rem;
               res_in = in_res >> 1;
            end
         end
      end else begin : g_root_hold
         always_comb begin
            rem_in = in_rem;
            res_in = in_res;
         end
      end

      if (K < Q_BITS) begin : g_unit
         localparam int B = Q_BITS - 1 - K;
         logic [2:0][DW-1:0] delta;
         always_comb begin
            for (int i = 0; i < 3; i++) begin
               delta[i] = (in_qs[i] << (B + 1)) + (DW'(in_s) << (2 * B));
               if (delta[i] <= in_r[i]) begin
                  r_in[i]  = in_r[i] - delta[i];
                  qs_in[i] = in_qs[i] + (DW'(in_s) << B);
                  q_in[i]  = in_q[i] | (Q_BITS'(1) << B);
               end else begin
                  r_in[i]  = in_r[i];
                  qs_in[i] = in_qs[i];
                  q_in[i]  = in_q[i];
               end
            end
         end
      end else begin : g_unit_hold
         always_comb begin
            r_in  = in_r;
            qs_in = in_qs;
            q_in  = in_q;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= in_s;
         zero_ff <= in_zero;
         neg_ff  <= in_neg;
         rem_ff  <= rem_in;
         res_ff  <= res_in;
         r_ff    <= r_in;
         qs_ff   <= qs_in;
         q_ff    <= q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_s     = s_ff;
   assign out_zero  = zero_ff;
   assign out_neg   = neg_ff;
   assign out_rem   = rem_ff;
   assign out_res   = res_ff;
   assign out_r     = r_ff;
   assign out_qs    = qs_ff;
   assign out_q     = q_ff;
endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for vector3_normalize: drives random and directed 3-vectors, predicts
// length and Q1.15 unit vector per beat, and checks each result beat in order.
// Depends on v3n_pkg and the vector3_normalize RTL.
`timescale 1ns / 1ps
module tb_top;
   import v3n_pkg::*;

   localparam int CB = 16;
   localparam int LATENCY = ((CB > 17) ? CB : 17) + 4;
   localparam longint LIMIT = 400000;

   typedef struct packed {
      logic signed [UNIT_BITS-1:0] ux;
      logic signed [UNIT_BITS-1:0] uy;
      logic signed [UNIT_BITS-1:0] uz;
      logic [CB-1:0]               mag;
      logic                        zero;
   } norm_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [CB-1:0] req_comp_x = '0, req_comp_y = '0, req_comp_z = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [UNIT_BITS-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic [CB-1:0] rsp_magnitude;
   logic rsp_zero_vector;

   norm_type expected_norms[$];
   int errors = 0;
   longint cycles = 0;
   int stall_mode = 0;

   vector3_normalize #(.COMPONENT_BITS(CB)) DUT (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [63:0] isqrt(logic [63:0] s);
      logic [63:0] r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= s) r |= 64'd1 << b;
      return r;
   endfunction

   // largest q with q^2 * s <= a^2 * 2^30
   function automatic logic [16:0] unit_quot(logic [63:0] a, logic [63:0] s);
      logic [16:0] q;
      logic [127:0] t;
      q = 0;
      for (int b = 16; b >= 0; b--) begin
         t = q | (17'd1 << b);
         if (t * t * s <= ((128'(a) * a) << 30)) q = t;
      end
      return q;
   endfunction

   function automatic norm_type predict_norm(logic signed [CB-1:0] x, y, z);
      logic signed [CB-1:0] c[3];
      logic [63:0] av[3];
      logic [63:0] s;
      logic [16:0] q;
      logic [UNIT_BITS-1:0] u[3];
      norm_type r;
      c[0] = x; c[1] = y; c[2] = z;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         av[i] = c[i] < 0 ? 64'(-65'(c[i])) : 64'(c[i]);
         s += av[i] * av[i];
      end
      if (s == 0) return '{ux: 0, uy: 0, uz: 0, mag: 0, zero: 1};
      for (int i = 0; i < 3; i++) begin
         q = unit_quot(av[i], s);
         if (c[i] < 0) u[i] = 16'(-q);
         else u[i] = (q > 17'(UNIT_MAX)) ? UNIT_MAX : q[15:0];
      end
      r.ux = u[0]; r.uy = u[1]; r.uz = u[2];
      r.mag = CB'(isqrt(s));
      r.zero = 0;
      return r;
   endfunction

   always @(posedge clock) begin
      norm_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{ux: rsp_unit_x, uy: rsp_unit_y, uz: rsp_unit_z,
                 mag: rsp_magnitude, zero: rsp_zero_vector};
         if (expected_norms.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat %p", $time, got);
         end else begin
            want = expected_norms.pop_front();
            if (got.ux !== want.ux) begin
               errors++;
               $display("%0t: unit_x exp %0d got %0d", $time, want.ux, got.ux);
            end
            if (got.uy !== want.uy) begin
               errors++;
               $display("%0t: unit_y exp %0d got %0d", $time, want.uy, got.uy);
            end
            if (got.uz !== want.uz) begin
               errors++;
               $display("%0t: unit_z exp %0d got %0d", $time, want.uz, got.uz);
            end
            if (got.mag !== want.mag) begin
               errors++;
               $display("%0t: magnitude exp %0d got %0d", $time, want.mag, got.mag);
            end
            if (got.zero !== want.zero) begin
               errors++;
               $display("%0t: zero_vector exp %0b got %0b", $time, want.zero, got.zero);
            end
         end
      end
   end

   // receiver stall pattern, mode changes per test
   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= (cycles % 16) < 5;
      endcase
   end

   int burst_left = 0;

   task automatic send_vector(logic signed [CB-1:0] x, y, z, bit gappy);
      int gap;
      if (gappy) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
               req_valid <= 0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
      end
      req_valid <= 1;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_norms.push_back(predict_norm(x, y, z));
   endtask

   task automatic drain_results();
      req_valid <= 0;
      @(posedge clock);
      while (expected_norms.size() != 0) @(posedge clock);
   endtask

   task automatic test_extremes();
      logic signed [CB-1:0] v[6];
      v = '{16'sh8000, 16'sh7FFF, 0, 1, -1, 16'sh8001};
      stall_mode = 0;
      send_vector(0, 0, 0, 0);
      for (int i = 0; i < 6; i++) begin
         send_vector(v[i], 0, 0, 0);
         send_vector(0, v[i], 0, 0);
         send_vector(0, 0, v[i], 0);
      end
      send_vector(16'sh8000, 16'sh8000, 16'sh8000, 0);
      send_vector(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
      send_vector(16'sh7FFF, 16'sh8000, 1, 0);
      send_vector(3, 4, 0, 0);
      send_vector(-2, 3, -6, 0);
   endtask

   function automatic logic signed [CB-1:0] rand_comp();
      case ($urandom_range(0, 4))
         0: return CB'(int'($urandom_range(0, 15)) - 8);
         1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         2: return CB'(int'($urandom_range(0, 511)) - 256);
         default: return CB'($urandom);
      endcase
   endfunction

   task automatic test_random(int n, int mode);
      stall_mode = mode;
      for (int i = 0; i < n; i++)
         send_vector(rand_comp(), rand_comp(), rand_comp(), mode != 0);
   endtask

   task automatic test_pause_until_empty();
      drain_results();
      send_vector(5, -7, 9, 0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_extremes();
      test_random(300, 0);
      test_random(500, 1);
      test_pause_until_empty();
      test_random(500, 2);
      test_random(620, 3);
      drain_results();
      repeat (LATENCY + 5) @(posedge clock);
      if (errors == 0 && expected_norms.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

### sim.f
sv/v3n_pkg.sv
sv/v3n_stage.sv
sv/vector3_normalize.sv
tb/tb_top.sv
